/* hdl/fwct_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwct_pkg
// Shared types and constants of the connection tracker.
// ----------------------------------------------------------------------------
package fwct_pkg;

  localparam int unsigned TableEntries = 64;

  localparam logic [7:0] ProtoIcmp   = 8'd1;
  localparam logic [7:0] ProtoTcp    = 8'd6;
  localparam logic [7:0] IcmpEchoReq = 8'd8;
  localparam logic [7:0] IcmpEchoRep = 8'd0;
  localparam int unsigned FlagFin = 0;
  localparam int unsigned FlagSyn = 1;
  localparam int unsigned FlagRst = 2;
  localparam int unsigned FlagAck = 4;

  typedef enum logic [1:0] {
    CfgIcmpTmo = 2'd0,
    CfgSynTmo  = 2'd1,
    CfgEstTmo  = 2'd2,
    CfgClsTmo  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ConnNew     = 2'd0,
    ConnEst     = 2'd1,
    ConnClosing = 2'd2
  } conn_state_e;

  typedef enum logic [2:0] {
    RsnOk      = 3'd0,
    RsnUnsup   = 3'd1,
    RsnDir     = 3'd2,
    RsnNoEnt   = 3'd3,
    RsnFull    = 3'd4,
    RsnExpired = 3'd5,
    RsnState   = 3'd6
  } reason_e;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StExec
  } fsm_e;

  typedef struct packed {
    logic [63:0] pair;
    logic [7:0]  proto;
    logic [47:0] aux;
  } key_t;

  typedef struct packed {
    conn_state_e state;
    logic [63:0] tmo;
  } sel_t;

  typedef struct packed {
    logic        we;
    logic        ins;
    logic        use_free;
    logic        set_state;
    conn_state_e state;
    logic        set_tmo;
    logic [63:0] tmo;
  } cmd_t;

endpackage

/* hdl/stateful_firewall_conn_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stateful_firewall_conn_tracker
// Connection tracking firewall verdicts over a row of entry cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// through the match step (key compare in every cell) and the exec step
// (lowest-entry claim along the cell chain with the table write-back), and the
// verdict shows on valid_o for one cycle right after. The result cannot be
// stalled. Timeout registers may be written at any time the block is idle.
module stateful_firewall_conn_tracker import fwct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        direction_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  proto_i,
  input  logic [7:0]  tcp_flag_bits_i,
  input  logic [15:0] src_port_num_i,
  input  logic [15:0] dst_port_num_i,
  input  logic [7:0]  icmp_kind_i,
  input  logic [7:0]  icmp_subcode_i,
  input  logic [15:0] icmp_ident_i,
  input  logic [15:0] icmp_seqno_i,
  input  logic [63:0] now_ticks_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic        accept_o,
  output logic [2:0]  verdict_reason_o
);

  fsm_e        state_q, state_d;
  logic [31:0] icmp_tmo_q, syn_tmo_q, est_tmo_q, cls_tmo_q;
  key_t        key_q;
  logic        inb_q;
  logic [7:0]  flags_q, kind_q;
  logic [63:0] now_q;
  logic        take;
  logic        cap;
  logic        exec;

  logic [TableEntries:0] chain_hit, chain_free;
  sel_t                  chain_sel [TableEntries+1];
  logic [TableEntries-1:0] sel_hit;
  cmd_t    cmd;
  reason_e rsn;
  logic        any_hit, any_free;
  sel_t        ent;
  logic [31:0] tmo_add;
  logic [64:0] tmo_sum;
  logic [63:0] tmo_sat;
  logic        syn, synack, finrst;

  assign take = start && !busy;
  assign cap  = (state_q == StMatch);
  assign exec = (state_q == StExec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      icmp_tmo_q <= 32'd100000000;
      syn_tmo_q  <= 32'd100000000;
      est_tmo_q  <= 32'd1000000000;
      cls_tmo_q  <= 32'd100000000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgIcmpTmo: icmp_tmo_q <= cfg_wdata_i;
        CfgSynTmo:  syn_tmo_q  <= cfg_wdata_i;
        CfgEstTmo:  est_tmo_q  <= cfg_wdata_i;
        CfgClsTmo:  cls_tmo_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      key_q.pair  <= {src_addr_i, dst_addr_i};
      key_q.proto <= proto_i;
      if (proto_i == ProtoTcp) begin
        key_q.aux <= {16'd0, src_port_num_i, dst_port_num_i};
      end else begin
        key_q.aux <= {icmp_kind_i, icmp_subcode_i, icmp_ident_i, icmp_seqno_i};
      end
      inb_q   <= direction_i;
      flags_q <= tcp_flag_bits_i;
      kind_q  <= icmp_kind_i;
      now_q   <= now_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      StIdle:  state_d = take ? StMatch : StIdle;
      StMatch: state_d = StExec;
      StExec:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    busy = (state_q != StIdle);
  end

  assign chain_hit[0]  = 1'b0;
  assign chain_free[0] = 1'b0;
  assign chain_sel[0]  = '0;

  for (genvar i = 0; i < TableEntries; i++) begin : g_cell
    fwct_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .key_i        (key_q),
      .cap_i        (cap),
      .claim_hit_i  (chain_hit[i]),
      .claim_hit_o  (chain_hit[i+1]),
      .claim_free_i (chain_free[i]),
      .claim_free_o (chain_free[i+1]),
      .sel_i        (chain_sel[i]),
      .sel_o        (chain_sel[i+1]),
      .sel_hit_o    (sel_hit[i]),
      .cmd_i        (cmd)
    );
  end

  assign any_hit  = chain_hit[TableEntries];
  assign any_free = chain_free[TableEntries];
  assign ent      = chain_sel[TableEntries];

  assign syn     = flags_q[FlagSyn] && !flags_q[FlagAck];
  assign synack  = flags_q[FlagSyn] && flags_q[FlagAck];
  assign finrst  = flags_q[FlagFin] || flags_q[FlagRst];

  always_comb begin
    if (key_q.proto == ProtoIcmp) begin
      tmo_add = icmp_tmo_q;
    end else if (syn) begin
      tmo_add = syn_tmo_q;
    end else if (finrst && !(inb_q && synack)) begin
      tmo_add = cls_tmo_q;
    end else begin
      tmo_add = est_tmo_q;
    end
    tmo_sum = {1'b0, now_q} + {33'd0, tmo_add};
    tmo_sat = tmo_sum[64] ? '1 : tmo_sum[63:0];
  end

  always_comb begin
    cmd           = '0;
    cmd.state     = ConnNew;
    cmd.tmo       = tmo_sat;
    cmd.use_free  = !any_hit;
    rsn           = RsnOk;
    if (key_q.proto == ProtoIcmp) begin
      if (kind_q == IcmpEchoReq) begin
        if (inb_q) begin
          rsn = RsnDir;
        end else if (!any_hit && !any_free) begin
          rsn = RsnFull;
        end else begin
          cmd.we = 1'b1; cmd.ins = 1'b1; cmd.set_state = 1'b1; cmd.set_tmo = 1'b1;
        end
      end else if (kind_q != IcmpEchoRep) begin
        rsn = RsnUnsup;
      end else if (!inb_q) begin
        rsn = RsnDir;
      end else if (!any_hit) begin
        rsn = RsnNoEnt;
      end else if (now_q > ent.tmo) begin
        rsn = RsnExpired;
      end else begin
        cmd.we = 1'b1; cmd.set_state = 1'b1; cmd.state = ConnEst;
      end
    end else if (key_q.proto == ProtoTcp) begin
      if (syn) begin
        if (inb_q) begin
          rsn = RsnDir;
        end else if (!any_hit && !any_free) begin
          rsn = RsnFull;
        end else begin
          cmd.we = 1'b1; cmd.ins = 1'b1; cmd.set_state = 1'b1; cmd.set_tmo = 1'b1;
        end
      end else if (!any_hit) begin
        rsn = RsnNoEnt;
      end else if (!inb_q) begin
        cmd.we = finrst; cmd.set_state = 1'b1; cmd.state = ConnClosing; cmd.set_tmo = 1'b1;
      end else if (synack) begin
        if (ent.state != ConnNew) begin
          rsn = RsnState;
        end else begin
          cmd.we = 1'b1; cmd.set_state = 1'b1; cmd.state = ConnEst; cmd.set_tmo = 1'b1;
        end
      end else if (finrst) begin
        cmd.we = 1'b1; cmd.set_state = 1'b1; cmd.state = ConnClosing; cmd.set_tmo = 1'b1;
      end else if (ent.state != ConnEst) begin
        rsn = RsnState;
      end else begin
        cmd.we = 1'b1; cmd.set_tmo = 1'b1;
      end
    end else begin
      rsn = RsnUnsup;
    end
    if (!exec) begin
      cmd.we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      accept_o         <= (rsn == RsnOk);
      verdict_reason_o <= rsn;
    end
  end

  a_res_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == StExec))
    else $error("result without exec step");
  a_match_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMatch) |=> (state_q == StExec))
    else $error("match step not followed by exec");
  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_hit))
    else $error("more than one entry selected");
  a_accept_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (accept_o == (verdict_reason_o == RsnOk)))
    else $error("accept disagrees with reason");

endmodule

/* hdl/fwct_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwct_cell
// One table entry: key compare, lowest-hit/free claim chain, write-back.
// ----------------------------------------------------------------------------
module fwct_cell import fwct_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  key_t  key_i,
  input  logic  cap_i,
  input  logic  claim_hit_i,
  output logic  claim_hit_o,
  input  logic  claim_free_i,
  output logic  claim_free_o,
  input  sel_t  sel_i,
  output sel_t  sel_o,
  output logic  sel_hit_o,
  input  cmd_t  cmd_i
);

  logic        valid_q;
  logic [63:0] pair_q;
  logic [7:0]  proto_q;
  logic [47:0] aux_q;
  conn_state_e state_q;
  logic [63:0] tmo_q;
  logic        hit_q, free_q;
  logic [47:0] in_aux;
  logic        match;
  logic        sel_hit, sel_free, we;

  always_comb begin
    if (proto_q == ProtoTcp) begin
      in_aux = {16'd0, aux_q[15:0], aux_q[31:16]};
    end else begin
      in_aux = {16'd0, aux_q[31:0]};
    end
    match = valid_q && (proto_q == key_i.proto) &&
            (((pair_q == key_i.pair) && (aux_q == key_i.aux)) ||
             (({pair_q[31:0], pair_q[63:32]} == key_i.pair) && (in_aux == key_i.aux)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cap_i) begin
      hit_q  <= match;
      free_q <= !valid_q;
    end
  end

  assign sel_hit      = hit_q && !claim_hit_i;
  assign sel_free     = free_q && !claim_free_i;
  assign claim_hit_o  = claim_hit_i | hit_q;
  assign claim_free_o = claim_free_i | free_q;
  assign sel_hit_o    = sel_hit;
  assign sel_o        = sel_hit ? sel_t'{state: state_q, tmo: tmo_q} : sel_i;
  assign we           = cmd_i.we && (cmd_i.use_free ? sel_free : sel_hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (we && cmd_i.ins) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (cmd_i.ins) begin
        pair_q  <= key_i.pair;
        proto_q <= key_i.proto;
        aux_q   <= key_i.aux;
      end
      if (cmd_i.set_state) begin
        state_q <= cmd_i.state;
      end
      if (cmd_i.set_tmo) begin
        tmo_q <= cmd_i.tmo;
      end
    end
  end

endmodule
